/* rtl/dmm_pkg.sv */
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared widths, register indexes and the saturating accumulate used by the
// dense matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

	localparam int ELEM_W = 32;
	localparam int ACC_W  = 64;
	localparam int CFG_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W  = 3;
	localparam int OUT_DATA_W = 72;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_W-1:0]         cfg_val_t;

	localparam cfg_idx_t REG_ROWS_A    = 2'd0;
	localparam cfg_idx_t REG_INNER_DIM = 2'd1;
	localparam cfg_idx_t REG_COLS_B    = 2'd2;

	localparam cfg_val_t DIM_RESET = 4'd8;

	// Add with clamp to the signed range instead of wrapping.
	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		acc_t sum;
		sum = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && sum[ACC_W-1] != a[ACC_W-1]) begin
			sum = b[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return sum;
	endfunction

endpackage

`default_nettype wire

/* rtl/dense_matrix_multiply_core.sv */
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Loads A then B row-major into two on-chip memories, then walks them to
// produce C = A * B in saturated Q32.32, one result per output request.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Contents
//  s_axis    tvalid tready tdata[31:0] tlast       element_value; tlast = last_element
//  m_axis    tvalid tready tdata[71:0] tlast       product_value, row, col; tlast = last_result
//  cfg       cfg_we cfg_index cfg_data             rows_a, inner_dim, cols_b
//
//  Loading takes one element per cycle; the input is held off during compute.
//  Each result is built from one memory read per k on the shared
//  read port pair, a product register, the accumulate, then the output load.
//  A stalled output register holds the walk before the next result starts.
//  Reset clears the control state; memory contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_multiply_core #(
	parameter int MAX_DIM = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [dmm_pkg::ELEM_W-1:0]        s_axis_tdata,  // [31:0] element_value
	input  wire                               s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [dmm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [63:0] product_value,
	                                                          // [66:64] row_index,
	                                                          // [69:67] col_index, rest 0
	output logic                              m_axis_tlast,
	input  wire                               cfg_we,
	input  wire  [dmm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [dmm_pkg::CFG_W-1:0]         cfg_data
);

	import dmm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int MW = (CW > DW) ? CW : DW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	cfg_val_t rows_a_q, inner_dim_q, cols_b_q;
	logic [DW-1:0] nr, nk, nc;

	logic [1:0]    state_q;
	logic [CW-1:0] load_count_q;
	logic          loading_b_q;
	logic [IW-1:0] i_q, j_q, k_q;

	elem_t store_a [2**AW];
	elem_t store_b [2**AW];

	elem_t a_s1, b_s1;
	logic  v_s1, first_s1, last_s1;
	acc_t  prod_s2;
	logic  v_s2, first_s2, last_s2;
	acc_t  acc_q;

	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_valid_q, out_last_q;

	logic          in_acc, out_free, issue;
	logic          cnt_room;
	logic [CW-1:0] cnt_inc, a_bound;
	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic          k_end, i_end, j_end;

	function automatic logic [DW-1:0] eff_dim(input cfg_val_t v);
		if (v == '0) begin
			return DW'(1);
		end else if (32'(v) > MAX_DIM) begin
			return DW'(MAX_DIM);
		end
		return DW'(v);
	endfunction

	assign nr = eff_dim(rows_a_q);
	assign nk = eff_dim(inner_dim_q);
	assign nc = eff_dim(cols_b_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign issue    = (state_q == ST_RUN);

	assign cnt_room = (32'(load_count_q) < DEPTH);
	assign cnt_inc  = cnt_room ? load_count_q + 1'b1 : load_count_q;
	assign a_bound  = CW'(MW'(nr) * MW'(nk));
	assign wr_addr  = AW'(load_count_q);

	assign rd_addr_a = AW'(MW'(i_q) * MW'(nk) + MW'(k_q));
	assign rd_addr_b = AW'(MW'(k_q) * MW'(nc) + MW'(j_q));

	assign k_end = (DW'(k_q) == nk - 1'b1);
	assign i_end = (DW'(i_q) == nr - 1'b1);
	assign j_end = (DW'(j_q) == nc - 1'b1);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories: one write port for loading, one registered read port each
	always_ff @(posedge clk) begin
		if (in_acc && !loading_b_q && cnt_room) begin
			store_a[wr_addr] <= s_axis_tdata;
		end
		a_s1 <= store_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (in_acc && loading_b_q && cnt_room) begin
			store_b[wr_addr] <= s_axis_tdata;
		end
		b_s1 <= store_b[rd_addr_b];
	end

	// Sequencer: load, then walk i, j, k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			load_count_q <= '0;
			loading_b_q  <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!loading_b_q) begin
							if (cnt_inc >= a_bound) begin
								loading_b_q  <= 1'b1;
								load_count_q <= '0;
							end else begin
								load_count_q <= cnt_inc;
							end
						end else if (s_axis_tlast) begin
							loading_b_q  <= 1'b0;
							load_count_q <= '0;
							i_q          <= '0;
							j_q          <= '0;
							k_q          <= '0;
							state_q      <= ST_RUN;
						end else begin
							load_count_q <= cnt_inc;
						end
					end
				end
				ST_RUN: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								i_q     <= '0;
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_RUN;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pipeline tags follow the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= k_end;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= ACC_W'(a_s1) * ACC_W'(b_s1);
		if (v_s2) begin
			acc_q <= sat_add(first_s2 ? '0 : acc_q, prod_s2);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= {2'b00, POS_W'(j_q), POS_W'(i_q), acc_q};
			out_last_q <= i_end && j_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// The final result carries the last row and column
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(DW'(m_axis_tdata[66:64]) == nr - 1'b1 && DW'(m_axis_tdata[69:67]) == nc - 1'b1))
		else $error("last result not at final row and column");

	// Closing B restarts loading at A and starts the walk
	a_close_b: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && loading_b_q && s_axis_tlast) |=>
		(state_q == ST_RUN && load_count_q == '0 && !loading_b_q))
		else $error("end of B did not start compute");

	// The accumulate pipe is empty when a result is handed over
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!v_s1 && !v_s2))
		else $error("result emitted with products in flight");

endmodule

`default_nettype wire
